// File: src/acc_pkg.sv
// shared types, constants and register codes of the auto contrast cursor colour block
`default_nettype none

package acc_pkg;

    // sample count range of the block; totals are sized for the largest count
    localparam int SAMPLE_COUNT_DEF = 8;
    localparam int SAMPLE_COUNT_MAX = 16;
    localparam int TOTAL_W_MAX      = $clog2(SAMPLE_COUNT_MAX * 255 + 1);

    // colour and divider widths
    localparam int COLOUR_W = 16;
    localparam int DIV_W    = 16;
    localparam int STEP_W   = 17;

    localparam logic [COLOUR_W-1:0] COLOUR_FULL = 16'hFFFF;
    localparam logic [STEP_W-1:0]   STEP_ONE    = 17'h10000;

    // queues between the parts, power of two depth
    localparam int FIFO_DEPTH = 2;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GREY_SAT_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_VAL_LIMIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DARK_MARK_LEVEL  = 2'd3;

    localparam logic [7:0]          RST_SMOOTHING_RATE   = 8'd15;
    localparam logic [COLOUR_W-1:0] RST_GREY_SAT_LIMIT   = 16'd13107;
    localparam logic [COLOUR_W-1:0] RST_BRIGHT_VAL_LIMIT = 16'd39322;
    localparam logic [COLOUR_W-1:0] RST_DARK_MARK_LEVEL  = 16'd3277;

    typedef struct packed {
        logic [7:0]          rate;
        logic [COLOUR_W-1:0] grey_limit;
        logic [COLOUR_W-1:0] bright_limit;
        logic [COLOUR_W-1:0] dark_level;
    } t_cfg;

    // one colour update handed from front to back
    typedef struct packed {
        logic                   fresh;
        logic [TOTAL_W_MAX-1:0] red_total;
        logic [TOTAL_W_MAX-1:0] green_total;
        logic [TOTAL_W_MAX-1:0] blue_total;
        logic [15:0]            frame_time;
    } t_cmd;

    typedef struct packed {
        logic [COLOUR_W-1:0] red;
        logic [COLOUR_W-1:0] green;
        logic [COLOUR_W-1:0] blue;
        logic                fresh;
    } t_res;

    typedef struct packed {
        logic                  start;
        logic [2*DIV_W-1:0]    num;
        logic [DIV_W-1:0]      den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
    } t_div_rsp;

endpackage

`default_nettype wire

// File: src/auto_contrast_cursor_color_top.sv
// top level of the auto contrast cursor colour block
//
// Background samples (command 0) are taken one per cycle while the command queue
// is not full, and summed; an update (command 1) is queued for the colour engine,
// which yields one result per update. The engine, when idle, takes an update as
// soon as it shows in the command queue. An update whose sample count matched runs
// four serial divisions in the divider (the saturation and three hue channels)
// when the target is a hue, and at most the saturation division when the background
// is grey; the three averages come from a reciprocal multiply, one channel a cycle.
// An update without a fresh target runs only the three fade steps, which share one
// multiplier. The engine holds its result while the result queue is full. A
// two-entry command queue lets samples and further updates arrive while the engine
// works; full is high only while two updates wait. Results sit in a two-entry
// queue until popped. Configuration may be written at any time the block is idle.
`default_nettype none

module auto_contrast_cursor_color_top #(
    parameter int SAMPLE_COUNT = acc_pkg::SAMPLE_COUNT_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [acc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [acc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic                         i_command,
    input  wire logic [7:0]                   i_red_in,
    input  wire logic [7:0]                   i_green_in,
    input  wire logic [7:0]                   i_blue_in,
    input  wire logic [15:0]                  i_frame_time,
    output logic                              empty,
    input  wire logic                         pop,
    output logic [acc_pkg::COLOUR_W-1:0]      o_red_out,
    output logic [acc_pkg::COLOUR_W-1:0]      o_green_out,
    output logic [acc_pkg::COLOUR_W-1:0]      o_blue_out,
    output logic                              o_target_fresh
);
    import acc_pkg::*;

    t_cfg     r_cfg;
    logic     cmd_push;
    t_cmd     cmd_in;
    logic     cmd_full;
    logic     cmd_pop;
    logic     cmd_empty;
    t_cmd     cmd_out;
    logic     res_push;
    t_res     res_in;
    logic     res_full;
    t_res     res_out;
    t_div_req div_req;
    t_div_rsp div_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate         <= RST_SMOOTHING_RATE;
            r_cfg.grey_limit   <= RST_GREY_SAT_LIMIT;
            r_cfg.bright_limit <= RST_BRIGHT_VAL_LIMIT;
            r_cfg.dark_level   <= RST_DARK_MARK_LEVEL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SMOOTHING_RATE:   r_cfg.rate         <= i_cfg_data[7:0];
                CFG_GREY_SAT_LIMIT:   r_cfg.grey_limit   <= i_cfg_data;
                CFG_BRIGHT_VAL_LIMIT: r_cfg.bright_limit <= i_cfg_data;
                CFG_DARK_MARK_LEVEL:  r_cfg.dark_level   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign full = cmd_full;

    acc_front #(
        .SAMPLE_COUNT(SAMPLE_COUNT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (push && !cmd_full),
        .i_command    (i_command),
        .i_red_in     (i_red_in),
        .i_green_in   (i_green_in),
        .i_blue_in    (i_blue_in),
        .i_frame_time (i_frame_time),
        .o_cmd_push   (cmd_push),
        .o_cmd        (cmd_in)
    );

    acc_fifo #(
        .WIDTH($bits(t_cmd))
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .o_full  (cmd_full),
        .i_data  (cmd_in),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_data  (cmd_out)
    );

    acc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    acc_back #(
        .SAMPLE_COUNT(SAMPLE_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_cmd       (cmd_out),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp)
    );

    acc_fifo #(
        .WIDTH($bits(t_res))
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .o_full  (res_full),
        .i_data  (res_in),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (res_out)
    );

    assign o_red_out      = res_out.red;
    assign o_green_out    = res_out.green;
    assign o_blue_out     = res_out.blue;
    assign o_target_fresh = res_out.fresh;

endmodule

`default_nettype wire

// File: src/acc_fifo.sv
// small register queue used between the front, the back and the result port
`default_nettype none

module acc_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    output logic                  o_full,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic [WIDTH-1:0]      o_data
);
    import acc_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNT_W'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: src/acc_front.sv
// front part: sums background samples and turns each update into a queued command
`default_nettype none

module acc_front #(
    parameter int SAMPLE_COUNT = acc_pkg::SAMPLE_COUNT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic        i_command,
    input  wire logic [7:0]  i_red_in,
    input  wire logic [7:0]  i_green_in,
    input  wire logic [7:0]  i_blue_in,
    input  wire logic [15:0] i_frame_time,
    output logic             o_cmd_push,
    output acc_pkg::t_cmd    o_cmd
);
    import acc_pkg::*;

    localparam int TOTAL_W = $clog2(SAMPLE_COUNT * 255 + 1);
    localparam int SEEN_W  = $clog2(SAMPLE_COUNT + 1);

    logic [TOTAL_W-1:0] r_red_total;
    logic [TOTAL_W-1:0] r_green_total;
    logic [TOTAL_W-1:0] r_blue_total;
    logic [SEEN_W-1:0]  r_seen;

    logic is_sample;

    assign is_sample  = i_accept && !i_command;
    assign o_cmd_push = i_accept && i_command;

    assign o_cmd.fresh       = (r_seen == SEEN_W'(SAMPLE_COUNT));
    assign o_cmd.red_total   = TOTAL_W_MAX'(r_red_total);
    assign o_cmd.green_total = TOTAL_W_MAX'(r_green_total);
    assign o_cmd.blue_total  = TOTAL_W_MAX'(r_blue_total);
    assign o_cmd.frame_time  = i_frame_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_total   <= '0;
            r_green_total <= '0;
            r_blue_total  <= '0;
            r_seen        <= '0;
        end else if (o_cmd_push) begin
            r_red_total   <= '0;
            r_green_total <= '0;
            r_blue_total  <= '0;
            r_seen        <= '0;
        end else if (is_sample && (r_seen < SEEN_W'(SAMPLE_COUNT))) begin
            // samples past the count are dropped
            r_red_total   <= r_red_total + TOTAL_W'(i_red_in);
            r_green_total <= r_green_total + TOTAL_W'(i_green_in);
            r_blue_total  <= r_blue_total + TOTAL_W'(i_blue_in);
            r_seen        <= r_seen + 1'b1;
        end
    end

endmodule

`default_nettype wire

// File: src/acc_div.sv
// serial restoring divider, one quotient bit per cycle, quotient known to fit DIV_W bits
`default_nettype none

module acc_div (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  acc_pkg::t_div_req  i_req,
    output acc_pkg::t_div_rsp  o_rsp
);
    import acc_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_lo;
    logic [DIV_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;

    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   trial;
    logic             fits;

    // remainder stays below the divisor, so one compare and subtract per bit
    assign shifted = {r_rem, r_lo[DIV_W-1]};
    assign fits    = (shifted >= {1'b0, r_den});
    assign trial   = shifted - {1'b0, r_den};

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt <= CNT_W'(DIV_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift in where dividend bits leave
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.num[2*DIV_W-1:DIV_W];
            r_lo  <= i_req.num[DIV_W-1:0];
            r_den <= i_req.den;
        end else if (r_cnt != '0) begin
            r_rem <= fits ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
            r_lo  <= {r_lo[DIV_W-2:0], fits};
        end
    end

endmodule

`default_nettype wire

// File: src/acc_back.sv
// back part: sequencer that averages, picks the target colour and fades the shown colour
`default_nettype none

module acc_back #(
    parameter int SAMPLE_COUNT = acc_pkg::SAMPLE_COUNT_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  acc_pkg::t_cfg      i_cfg,
    input  wire logic          i_cmd_empty,
    output logic               o_cmd_pop,
    input  acc_pkg::t_cmd      i_cmd,
    input  wire logic          i_res_full,
    output logic               o_res_push,
    output acc_pkg::t_res      o_res,
    output acc_pkg::t_div_req  o_div_req,
    input  acc_pkg::t_div_rsp  i_div_rsp
);
    import acc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AVG,
        ST_CLASS,
        ST_SAT,
        ST_SAT_WAIT,
        ST_DECIDE,
        ST_TGT,
        ST_TGT_WAIT,
        ST_STEP,
        ST_MUL,
        ST_APPLY,
        ST_OUT
    } t_state;

    localparam logic [1:0] LAST_CH = 2'd2;

    // floor(x / SAMPLE_COUNT) for any x below 2^AVG_X_W by a rounded-up reciprocal
    localparam int AVG_X_W = 20;
    localparam int AVG_SH  = AVG_X_W + $clog2(SAMPLE_COUNT);
    localparam int AVG_MUL = ((1 << AVG_SH) + SAMPLE_COUNT - 1) / SAMPLE_COUNT;
    localparam int AVG_P_W = 2 * AVG_X_W + 1;

    t_state               r_state;
    logic [1:0]           r_ch;
    t_div_req             r_div_req;
    logic [TOTAL_W_MAX-1:0] r_tot [3];
    logic [COLOUR_W-1:0]  r_avg [3];
    logic [COLOUR_W-1:0]  r_tgt [3];
    logic [COLOUR_W-1:0]  r_shown [3];
    logic                 r_fresh;
    logic [15:0]          r_ft;
    logic [COLOUR_W-1:0]  r_hi;
    logic [COLOUR_W-1:0]  r_chroma;
    logic [COLOUR_W-1:0]  r_sat;
    logic [STEP_W-1:0]    r_step;
    logic [32:0]          r_prod;
    logic                 r_up;

    logic [COLOUR_W-1:0]  hi_c;
    logic [COLOUR_W-1:0]  lo_c;
    logic [AVG_X_W-1:0]   avg_num;
    logic [AVG_P_W-1:0]   avg_prod;
    logic [COLOUR_W-1:0]  kd;
    logic [23:0]          step_prod;
    logic                 up_c;
    logic [COLOUR_W-1:0]  diff_c;
    logic [32:0]          prod_c;
    logic [33:0]          rnd;

    function automatic logic [COLOUR_W-1:0] max3(input logic [COLOUR_W-1:0] a,
                                                 input logic [COLOUR_W-1:0] b,
                                                 input logic [COLOUR_W-1:0] c);
        logic [COLOUR_W-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic logic [COLOUR_W-1:0] min3(input logic [COLOUR_W-1:0] a,
                                                 input logic [COLOUR_W-1:0] b,
                                                 input logic [COLOUR_W-1:0] c);
        logic [COLOUR_W-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    assign hi_c = max3(r_avg[0], r_avg[1], r_avg[2]);
    assign lo_c = min3(r_avg[0], r_avg[1], r_avg[2]);

    // total * 257, the quotient by the count is the Q0.16 average
    assign avg_num  = {r_tot[r_ch], 8'h00} + {8'h00, r_tot[r_ch]};
    assign avg_prod = AVG_P_W'(avg_num) * AVG_P_W'(AVG_MUL);

    // complement minus its minimum equals max minus channel
    assign kd = r_hi - r_avg[r_ch];

    assign step_prod = {8'h00, r_ft} * {16'h0000, i_cfg.rate};

    assign up_c   = (r_tgt[r_ch] >= r_shown[r_ch]);
    assign diff_c = up_c ? (r_tgt[r_ch] - r_shown[r_ch]) : (r_shown[r_ch] - r_tgt[r_ch]);
    assign prod_c = {17'h00000, diff_c} * {16'h0000, r_step};

    // falling channels round the move up so the floor goes toward minus infinity
    assign rnd = {1'b0, r_prod} + 34'd65535;

    assign o_cmd_pop  = (r_state == ST_IDLE) && !i_cmd_empty;
    assign o_res_push = (r_state == ST_OUT) && !i_res_full;
    assign o_div_req  = r_div_req;

    assign o_res.red   = r_shown[0];
    assign o_res.green = r_shown[1];
    assign o_res.blue  = r_shown[2];
    assign o_res.fresh = r_fresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_ch            <= '0;
            r_div_req.start <= 1'b0;
            r_shown[0]      <= '0;
            r_shown[1]      <= COLOUR_FULL;
            r_shown[2]      <= COLOUR_FULL;
        end else begin
            r_div_req.start <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    r_tgt <= r_shown;
                    r_ch  <= '0;
                    if (!i_cmd_empty) begin
                        r_tot[0] <= i_cmd.red_total;
                        r_tot[1] <= i_cmd.green_total;
                        r_tot[2] <= i_cmd.blue_total;
                        r_fresh  <= i_cmd.fresh;
                        r_ft     <= i_cmd.frame_time;
                        r_state  <= i_cmd.fresh ? ST_AVG : ST_STEP;
                    end
                end
                ST_AVG: begin
                    r_avg[r_ch] <= avg_prod[AVG_SH +: COLOUR_W];
                    if (r_ch == LAST_CH) begin
                        r_ch    <= '0;
                        r_state <= ST_CLASS;
                    end else begin
                        r_ch    <= r_ch + 1'b1;
                    end
                end
                ST_CLASS: begin
                    r_hi     <= hi_c;
                    r_chroma <= hi_c - lo_c;
                    r_state  <= ST_SAT;
                end
                ST_SAT: begin
                    if (r_hi == '0) begin
                        r_sat   <= '0;
                        r_state <= ST_DECIDE;
                    end else begin
                        r_div_req.start <= 1'b1;
                        r_div_req.num   <= {r_chroma, 16'h0000} - {16'h0000, r_chroma};
                        r_div_req.den   <= r_hi;
                        r_state         <= ST_SAT_WAIT;
                    end
                end
                ST_SAT_WAIT: begin
                    if (i_div_rsp.done) begin
                        r_sat   <= i_div_rsp.quot;
                        r_state <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    if (r_sat < i_cfg.grey_limit) begin
                        if (r_hi > i_cfg.bright_limit) begin
                            r_tgt[0] <= i_cfg.dark_level;
                            r_tgt[1] <= i_cfg.dark_level;
                            r_tgt[2] <= i_cfg.dark_level;
                        end else begin
                            r_tgt[0] <= '0;
                            r_tgt[1] <= COLOUR_FULL;
                            r_tgt[2] <= COLOUR_FULL;
                        end
                        r_state <= ST_STEP;
                    end else if (r_chroma == '0) begin
                        // no hue at all: take red
                        r_tgt[0] <= COLOUR_FULL;
                        r_tgt[1] <= '0;
                        r_tgt[2] <= '0;
                        r_state  <= ST_STEP;
                    end else begin
                        r_ch    <= '0;
                        r_state <= ST_TGT;
                    end
                end
                ST_TGT: begin
                    r_div_req.start <= 1'b1;
                    r_div_req.num   <= {kd, 16'h0000} - {16'h0000, kd};
                    r_div_req.den   <= r_chroma;
                    r_state         <= ST_TGT_WAIT;
                end
                ST_TGT_WAIT: begin
                    if (i_div_rsp.done) begin
                        r_tgt[r_ch] <= i_div_rsp.quot;
                        if (r_ch == LAST_CH) begin
                            r_ch    <= '0;
                            r_state <= ST_STEP;
                        end else begin
                            r_ch    <= r_ch + 1'b1;
                            r_state <= ST_TGT;
                        end
                    end
                end
                ST_STEP: begin
                    r_step  <= (step_prod > 24'(STEP_ONE)) ? STEP_ONE : step_prod[STEP_W-1:0];
                    r_ch    <= '0;
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_up    <= up_c;
                    r_prod  <= prod_c;
                    r_state <= ST_APPLY;
                end
                ST_APPLY: begin
                    if (r_up) begin
                        r_shown[r_ch] <= r_shown[r_ch] + r_prod[31:16];
                    end else begin
                        r_shown[r_ch] <= r_shown[r_ch] - rnd[31:16];
                    end
                    if (r_ch == LAST_CH) begin
                        r_ch    <= '0;
                        r_state <= ST_OUT;
                    end else begin
                        r_ch    <= r_ch + 1'b1;
                        r_state <= ST_MUL;
                    end
                end
                ST_OUT: begin
                    if (!i_res_full) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: src/acc_checker.sv
// port-level checker of the top level and its bind
`default_nettype none

module acc_checker (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    push,
    input wire logic                    full,
    input wire logic                    i_command,
    input wire logic                    empty,
    input wire logic                    pop,
    input wire logic [acc_pkg::COLOUR_W-1:0] o_red_out,
    input wire logic [acc_pkg::COLOUR_W-1:0] o_green_out,
    input wire logic [acc_pkg::COLOUR_W-1:0] o_blue_out,
    input wire logic                    o_target_fresh
);

    // both queues come out of reset empty
    a_reset_queues: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not cleared by reset");

    // a waiting result holds until it is transferred
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_red_out) && $stable(o_green_out)
                              && $stable(o_blue_out) && $stable(o_target_fresh)))
        else $error("waiting result changed or vanished");

    // the input side fills only through an accepted update
    a_full_from_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push && !full && i_command))
        else $error("full rose without an accepted update");

    // results leave only by a transfer
    a_empty_from_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(empty) |-> $past(pop))
        else $error("result lost without a transfer");

endmodule

bind auto_contrast_cursor_color_top acc_checker u_acc_checker (.*);

`default_nettype wire

// File: dv/testbench.sv
// testbench for the auto contrast cursor colour block, checked against a colour predictor
`timescale 1ns / 100ps

module testbench;

    import acc_pkg::*;

    localparam int          N_SAMPLES       = SAMPLE_COUNT_DEF;
    localparam int          ITEMS_PER_PHASE = 210;
    localparam int          N_PHASES        = 8;
    localparam int          SETTLE_CYCLES   = 250;
    localparam int unsigned MAX_REPORTS     = 10;

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_UPDATE = 1'b1
    } t_colour_cmd;

    class t_colour_scoreboard;
        logic [7:0]             rate;
        logic [COLOUR_W-1:0]    grey_limit;
        logic [COLOUR_W-1:0]    bright_limit;
        logic [COLOUR_W-1:0]    dark_level;
        logic [TOTAL_W_MAX-1:0] red_sum;
        logic [TOTAL_W_MAX-1:0] green_sum;
        logic [TOTAL_W_MAX-1:0] blue_sum;
        int unsigned            sample_cnt;
        logic [COLOUR_W-1:0]    shown_r;
        logic [COLOUR_W-1:0]    shown_g;
        logic [COLOUR_W-1:0]    shown_b;
        t_res                   awaited_colours[$];
        int unsigned            fail_count;

        function new();
            rate         = RST_SMOOTHING_RATE;
            grey_limit   = RST_GREY_SAT_LIMIT;
            bright_limit = RST_BRIGHT_VAL_LIMIT;
            dark_level   = RST_DARK_MARK_LEVEL;
            red_sum      = '0;
            green_sum    = '0;
            blue_sum     = '0;
            sample_cnt   = 0;
            shown_r      = '0;
            shown_g      = COLOUR_FULL;
            shown_b      = COLOUR_FULL;
            fail_count   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SMOOTHING_RATE:   rate         = data[7:0];
                CFG_GREY_SAT_LIMIT:   grey_limit   = data;
                CFG_BRIGHT_VAL_LIMIT: bright_limit = data;
                CFG_DARK_MARK_LEVEL:  dark_level   = data;
                default: ;
            endcase
        endfunction

        // move one channel toward its target, rounding toward minus infinity
        function logic [COLOUR_W-1:0] fade(logic [COLOUR_W-1:0] cur, logic [COLOUR_W-1:0] tgt,
                                           longint unsigned step);
            longint unsigned diff;
            if (tgt >= cur) begin
                diff = tgt - cur;
                return cur + COLOUR_W'((diff * step) >> 16);
            end
            diff = cur - tgt;
            return cur - COLOUR_W'((diff * step + 65535) >> 16);
        endfunction

        function void note_input(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                 logic [15:0] ft);
            longint unsigned ar, ag, ab, hi, lo, chroma, sat, kr, kg, kb, kmin, step;
            logic [COLOUR_W-1:0] tr, tg, tb;
            logic                fresh;
            t_res                res;
            if (cmd == CMD_SAMPLE) begin
                if (sample_cnt < N_SAMPLES) begin
                    red_sum   += r;
                    green_sum += g;
                    blue_sum  += b;
                    sample_cnt++;
                end
                return;
            end
            tr    = shown_r;
            tg    = shown_g;
            tb    = shown_b;
            fresh = 1'b0;
            if (sample_cnt == N_SAMPLES) begin
                ar = (longint'(red_sum) * 257) / N_SAMPLES;
                ag = (longint'(green_sum) * 257) / N_SAMPLES;
                ab = (longint'(blue_sum) * 257) / N_SAMPLES;
                hi = ar;
                if (ag > hi) hi = ag;
                if (ab > hi) hi = ab;
                lo = ar;
                if (ag < lo) lo = ag;
                if (ab < lo) lo = ab;
                chroma = hi - lo;
                sat    = (hi != 0) ? (chroma * 65535) / hi : 0;
                fresh  = 1'b1;
                if (sat < grey_limit) begin
                    if (hi > bright_limit) begin
                        tr = dark_level;
                        tg = dark_level;
                        tb = dark_level;
                    end else begin
                        tr = '0;
                        tg = COLOUR_FULL;
                        tb = COLOUR_FULL;
                    end
                end else if (chroma == 0) begin
                    // no hue to speak of, red is taken
                    tr = COLOUR_FULL;
                    tg = '0;
                    tb = '0;
                end else begin
                    kr   = 65535 - ar;
                    kg   = 65535 - ag;
                    kb   = 65535 - ab;
                    kmin = kr;
                    if (kg < kmin) kmin = kg;
                    if (kb < kmin) kmin = kb;
                    tr = COLOUR_W'(((kr - kmin) * 65535) / chroma);
                    tg = COLOUR_W'(((kg - kmin) * 65535) / chroma);
                    tb = COLOUR_W'(((kb - kmin) * 65535) / chroma);
                end
            end
            red_sum    = '0;
            green_sum  = '0;
            blue_sum   = '0;
            sample_cnt = 0;
            step = longint'(ft) * rate;
            if (step > 65536) step = 65536;
            shown_r = fade(shown_r, tr, step);
            shown_g = fade(shown_g, tg, step);
            shown_b = fade(shown_b, tb, step);
            res.red   = shown_r;
            res.green = shown_g;
            res.blue  = shown_b;
            res.fresh = fresh;
            awaited_colours.insert(awaited_colours.size(), res);
        endfunction

        function void check_result(logic [COLOUR_W-1:0] r, logic [COLOUR_W-1:0] g,
                                   logic [COLOUR_W-1:0] b, logic fresh);
            t_res want;
            if (awaited_colours.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected colour: r=%0d g=%0d b=%0d fresh=%0b", r, g, b, fresh);
                return;
            end
            want = awaited_colours.pop_front();
            if (r !== want.red || g !== want.green || b !== want.blue
                || fresh !== want.fresh) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display({"colour mismatch: expected r=%0d g=%0d b=%0d fresh=%0b,",
                              " got r=%0d g=%0d b=%0d fresh=%0b"},
                             want.red, want.green, want.blue, want.fresh, r, g, b, fresh);
            end
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  push        = 1'b0;
    logic                  full;
    logic                  i_command   = 1'b0;
    logic [7:0]            i_red_in    = '0;
    logic [7:0]            i_green_in  = '0;
    logic [7:0]            i_blue_in   = '0;
    logic [15:0]           i_frame_time = '0;
    logic                  empty;
    logic                  pop         = 1'b0;
    logic [COLOUR_W-1:0]   o_red_out;
    logic [COLOUR_W-1:0]   o_green_out;
    logic [COLOUR_W-1:0]   o_blue_out;
    logic                  o_target_fresh;

    int unsigned send_idle_pct = 0;
    int unsigned pop_stall_pct = 0;
    int unsigned items_sent    = 0;

    t_colour_scoreboard sb = new();

    auto_contrast_cursor_color_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_command      (i_command),
        .i_red_in       (i_red_in),
        .i_green_in     (i_green_in),
        .i_blue_in      (i_blue_in),
        .i_frame_time   (i_frame_time),
        .empty          (empty),
        .pop            (pop),
        .o_red_out      (o_red_out),
        .o_green_out    (o_green_out),
        .o_blue_out     (o_blue_out),
        .o_target_fresh (o_target_fresh)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        pop <= i_rst_n && ($urandom_range(99) >= pop_stall_pct);
    end

    // both sides of every transfer are seen here
    always @(posedge i_clk) begin
        if (i_rst_n && push && !full)
            sb.note_input(i_command, i_red_in, i_green_in, i_blue_in, i_frame_time);
        if (i_rst_n && pop && !empty)
            sb.check_result(o_red_out, o_green_out, o_blue_out, o_target_fresh);
    end

    task automatic send_item(input logic cmd, input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input logic [15:0] ft);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push         <= 1'b1;
        i_command    <= cmd;
        i_red_in     <= r;
        i_green_in   <= g;
        i_blue_in    <= b;
        i_frame_time <= ft;
        do @(posedge i_clk); while (full);
        items_sent++;
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (sb.awaited_colours.size() != 0) @(posedge i_clk);
    endtask

    // a sample set still in flight gives no result, so give the engine time to finish
    task automatic settle_block();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [7:0] rate, input logic [15:0] grey,
                                 input logic [15:0] bright, input logic [15:0] dark);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SMOOTHING_RATE;
        i_cfg_data  <= {8'($urandom), rate};
        @(posedge i_clk);
        sb.write_reg(i_cfg_index, i_cfg_data);
        i_cfg_index <= CFG_GREY_SAT_LIMIT;
        i_cfg_data  <= grey;
        @(posedge i_clk);
        sb.write_reg(i_cfg_index, i_cfg_data);
        i_cfg_index <= CFG_BRIGHT_VAL_LIMIT;
        i_cfg_data  <= bright;
        @(posedge i_clk);
        sb.write_reg(i_cfg_index, i_cfg_data);
        i_cfg_index <= CFG_DARK_MARK_LEVEL;
        i_cfg_data  <= dark;
        @(posedge i_clk);
        sb.write_reg(i_cfg_index, i_cfg_data);
        i_cfg_we <= 1'b0;
    endtask

    // one frame: a batch of background samples followed by an update
    task automatic send_frame();
        int unsigned count;
        int unsigned style;
        int          jitter;
        int          v;
        logic [7:0]  base [3];
        logic [7:0]  px [3];
        logic [15:0] ft;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5, 6: begin
                count = N_SAMPLES;
                if ($urandom_range(4) == 0) count += $urandom_range(1, 4);
            end
            7, 8:    count = $urandom_range(N_SAMPLES - 1);
            default: count = $urandom_range(N_SAMPLES + 3);
        endcase
        style = $urandom_range(3);
        for (int c = 0; c < 3; c++)
            base[c] = (style == 3) ? ($urandom_range(1) ? 8'hFF : 8'h00) : 8'($urandom);
        if (style == 2) begin
            base[1] = base[0];
            base[2] = base[0];
        end
        jitter = (style == 1 || style == 2) ? int'($urandom_range(12)) : 0;
        for (int n = 0; n < count; n++) begin
            for (int c = 0; c < 3; c++) begin
                if (style == 0) begin
                    px[c] = 8'($urandom);
                end else begin
                    v = int'(base[c]) + int'($urandom_range(2 * jitter)) - jitter;
                    if (v < 0) v = 0;
                    if (v > 255) v = 255;
                    px[c] = 8'(v);
                end
            end
            send_item(CMD_SAMPLE, px[0], px[1], px[2], 16'($urandom));
        end
        case ($urandom_range(9))
            0, 1, 2, 3, 4: ft = 16'($urandom_range(600));
            5, 6, 7:       ft = 16'($urandom);
            8:             ft = 16'h0000;
            default:       ft = 16'hFFFF;
        endcase
        send_item(CMD_UPDATE, 8'($urandom), 8'($urandom), 8'($urandom), ft);
    endtask

    initial begin
        int unsigned phase_start;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // update with no samples keeps the colour
        send_item(CMD_UPDATE, 8'h00, 8'h00, 8'h00, 16'h0000);
        // bright grey background, full step to the dark mark
        repeat (N_SAMPLES) send_item(CMD_SAMPLE, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
        send_item(CMD_UPDATE, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
        // too few samples
        repeat (3) send_item(CMD_SAMPLE, 8'd200, 8'd10, 8'd90, 16'h0000);
        send_item(CMD_UPDATE, 8'h00, 8'h00, 8'h00, 16'd1000);
        settle_block();

        // no grey band: a flat colour has no hue, plus one sample too many
        load_settings(RST_SMOOTHING_RATE, 16'd0, RST_BRIGHT_VAL_LIMIT, RST_DARK_MARK_LEVEL);
        repeat (N_SAMPLES) send_item(CMD_SAMPLE, 8'd100, 8'd100, 8'd100, 16'h0000);
        send_item(CMD_SAMPLE, 8'hFF, 8'h00, 8'h00, 16'h0000);
        send_item(CMD_UPDATE, 8'h00, 8'h00, 8'h00, 16'd2000);
        settle_block();

        for (int phase = 0; phase < N_PHASES; phase++) begin
            case (phase)
                0:       load_settings(8'd255, 16'd0, 16'hFFFF, 16'd0);
                1:       load_settings(8'd0, 16'hFFFF, 16'd0, 16'hFFFF);
                2:       load_settings(8'd1, RST_GREY_SAT_LIMIT, RST_BRIGHT_VAL_LIMIT,
                                       RST_DARK_MARK_LEVEL);
                7:       load_settings(8'($urandom), 16'($urandom), 16'($urandom),
                                       16'($urandom));
                default: load_settings(8'($urandom_range(1, 40)), 16'($urandom),
                                       16'($urandom), 16'($urandom));
            endcase
            case (phase % 4)
                0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
                1: begin send_idle_pct = 76; pop_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  pop_stall_pct = 76; end
                default: begin send_idle_pct = 35; pop_stall_pct = 35; end
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < ITEMS_PER_PHASE) begin
                send_frame();
                if ($urandom_range(15) == 0) wait_drained();
            end
            settle_block();
        end

        if (sb.fail_count == 0 && sb.awaited_colours.size() == 0) begin
            $display("[auto_contrast_cursor_color_top] OK");
        end else begin
            $display("[auto_contrast_cursor_color_top] ERROR");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("[auto_contrast_cursor_color_top] ERROR");
        $finish;
    end

endmodule

// File: files.f
src/acc_pkg.sv
src/acc_fifo.sv
src/acc_front.sv
src/acc_div.sv
src/acc_back.sv
src/auto_contrast_cursor_color_top.sv
src/acc_checker.sv
dv/testbench.sv
